@@ src/efws_pkg.sv @@
// Shared types and constants for the earliest-free-worker scheduler.
package efws_pkg;

   // Field widths fixed by the stream payloads
   localparam int TIME_W  = 48;
   localparam int DELAY_W = 24;
   localparam int DUR_W   = 32;
   localparam int WCNT_W  = 9;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [WCNT_W-1:0] WCNT_RESET = 9'd256;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 144;

   // Control sequencer
   typedef enum logic [0:0] {
      S_IDLE,
      S_INSERT
   } state_type;

   // Operation broadcast to every cell of the sorted chain
   typedef struct packed {
      logic              shift;   // remove head, every cell takes its right neighbor
      logic              insert;  // sorted insert of key
      logic [TIME_W-1:0] key;
   } chain_op_type;

endpackage

@@ src/efws_cell.sv @@
// One cell of the sorted finish-time chain: holds one entry and trades with its neighbors.
module efws_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  efws_pkg::chain_op_type       op,
   input  logic [efws_pkg::TIME_W-1:0]  left_val,
   input  logic                         left_valid,
   input  logic                         left_le,
   input  logic [efws_pkg::TIME_W-1:0]  right_val,
   input  logic                         right_valid,
   output logic [efws_pkg::TIME_W-1:0]  val,
   output logic                         valid,
   output logic                         le
);

   logic [efws_pkg::TIME_W-1:0] val_ff, val_in;
   logic                        valid_ff, valid_in;

   // Entry is at or below the key; empty cells count as +infinity
   assign le = valid_ff && (val_ff <= op.key);

   // Next entry: shift left on removal, open a slot at the insert point
   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (op.shift) begin
         val_in   = right_val;
         valid_in = right_valid;
      end else if (op.insert) begin
         if (le) begin
            val_in   = val_ff;
            valid_in = valid_ff;
         end else if (left_le) begin
            val_in   = op.key;
            valid_in = 1'b1;
         end else begin
            val_in   = left_val;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

@@ src/efws_chain.sv @@
// Row of cells keeping busy workers' finish times sorted, smallest at the head.
module efws_chain #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  efws_pkg::chain_op_type       op,
   output logic [efws_pkg::TIME_W-1:0]  head_val,
   output logic                         head_valid
);

   logic [efws_pkg::TIME_W-1:0] cell_val   [DEPTH];
   logic                        cell_valid [DEPTH];
   logic                        cell_le    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [efws_pkg::TIME_W-1:0] lval, rval;
      logic                        lvalid, lle, rvalid;

      // Boundary cells see an always-smaller left and an empty right
      if (i == 0) begin : g_first
         assign lval   = '0;
         assign lvalid = 1'b0;
         assign lle    = 1'b1;
      end else begin : g_mid
         assign lval   = cell_val[i-1];
         assign lvalid = cell_valid[i-1];
         assign lle    = cell_le[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign rval   = '0;
         assign rvalid = 1'b0;
      end else begin : g_next
         assign rval   = cell_val[i+1];
         assign rvalid = cell_valid[i+1];
      end

      efws_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_val    (lval),
         .left_valid  (lvalid),
         .left_le     (lle),
         .right_val   (rval),
         .right_valid (rvalid),
         .val         (cell_val[i]),
         .valid       (cell_valid[i]),
         .le          (cell_le[i])
      );
   end

   assign head_val   = cell_val[0];
   assign head_valid = cell_valid[0];

endmodule

@@ src/earliest_free_worker_scheduler.sv @@
// Top level: job stream in, finish/release/makespan stream out, worker count register.
//
//   channel | direction | fields (low bit first)
//   --------+-----------+------------------------------------------------
//   req     | in        | assign_delay[23:0], job_duration[55:24]
//   rsp     | out       | finish_time[47:0], released_time[95:48], makespan[143:96]
//   csr     | in        | worker_count[8:0], always ready
//
// On the accept beat a job removes the head of the cell chain when all workers
// are busy and forms the new clock and finish time; the insert state then puts the
// finish time into the chain and loads the output register. The chain's single
// remove and single insert per job set the rate. A stalled rsp holds the insert
// state, and req is not ready until the result is placed. Reset is synchronous,
// active high, and empties the chain at once; worker_count resets to 256.
module earliest_free_worker_scheduler #(
   parameter int MAX_WORKERS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [efws_pkg::REQ_DATA_W-1:0]    req_tdata,   // assign_delay, job_duration
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [efws_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // finish, released, makespan
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [efws_pkg::WCNT_W-1:0]        csr_wdata
);

   localparam int CNT_W = $clog2(MAX_WORKERS + 1);
   localparam int CMP_W = (CNT_W > efws_pkg::WCNT_W) ? CNT_W : efws_pkg::WCNT_W;
   localparam int TW    = efws_pkg::TIME_W;

   efws_pkg::state_type    state_ff, state_in;
   efws_pkg::chain_op_type chain_op;

   logic [efws_pkg::WCNT_W-1:0] wcount_ff;
   logic [CNT_W-1:0]            busy_ff, busy_in;
   logic [TW-1:0]               clock_now_ff, clock_now_in;
   logic [TW-1:0]               max_finish_ff;
   logic [TW-1:0]               finish_ff, finish_in;
   logic [TW-1:0]               released_ff, released_in;
   logic                        rsp_valid_ff;
   logic [TW-1:0]               rsp_finish_ff, rsp_released_ff, rsp_makespan_ff;

   logic [TW-1:0]               head_val;
   logic                        head_valid;

   logic                        req_beat, rsp_beat, out_free;
   logic                        do_accept, do_insert, need_pop;
   logic [CMP_W-1:0]            workers, wcount_ext, busy_ext;
   logic [efws_pkg::DELAY_W-1:0] delay;
   logic [efws_pkg::DUR_W-1:0]  duration;
   logic [TW-1:0]               base;
   logic [TW:0]                 clock_sum;
   logic [TW+1:0]               finish_sum;
   logic [TW-1:0]               makespan_new;

   assign delay    = req_tdata[efws_pkg::DELAY_W-1:0];
   assign duration = req_tdata[efws_pkg::DELAY_W +: efws_pkg::DUR_W];

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_valid_ff && rsp_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff <= efws_pkg::WCNT_RESET;
      end else if (csr_valid && csr_ready) begin
         wcount_ff <= csr_wdata;
      end
   end

   // Workers in use: zero means one, capped at the chain depth
   assign wcount_ext = CMP_W'(wcount_ff);
   assign busy_ext   = CMP_W'(busy_ff);
   always_comb begin
      if (wcount_ext == '0) begin
         workers = CMP_W'(1);
      end else if (wcount_ext > CMP_W'(MAX_WORKERS)) begin
         workers = CMP_W'(MAX_WORKERS);
      end else begin
         workers = wcount_ext;
      end
   end
   assign need_pop = (busy_ff != '0) && (busy_ext >= workers);

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         efws_pkg::S_IDLE: begin
            if (req_beat) state_in = efws_pkg::S_INSERT;
         end
         efws_pkg::S_INSERT: begin
            if (out_free) state_in = efws_pkg::S_IDLE;
         end
         default: state_in = efws_pkg::S_IDLE;
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      do_insert  = 1'b0;
      case (state_ff)
         efws_pkg::S_IDLE:   req_tready = 1'b1;
         efws_pkg::S_INSERT: do_insert  = out_free;
         default: begin
            req_tready = 1'b0;
            do_insert  = 1'b0;
         end
      endcase
   end
   assign do_accept = req_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efws_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Accept beat: release the earliest worker when all are busy, advance and extend the clock
   assign base = (need_pop && (head_val > clock_now_ff)) ? head_val : clock_now_ff;
   assign clock_sum  = {1'b0, base} + (TW+1)'(delay);
   assign finish_sum = {2'b00, base} + (TW+2)'(delay) + (TW+2)'(duration);

   always_comb begin
      clock_now_in = clock_now_ff;
      finish_in    = finish_ff;
      released_in  = released_ff;
      if (do_accept) begin
         clock_now_in = clock_sum[TW] ? efws_pkg::TIME_MAX : clock_sum[TW-1:0];
         finish_in    = (finish_sum[TW+1:TW] != 2'b00) ? efws_pkg::TIME_MAX
                                                      : finish_sum[TW-1:0];
         released_in  = need_pop ? head_val : clock_now_ff;
      end
   end

   // Busy count: down on removal, up on insert
   always_comb begin
      busy_in = busy_ff;
      if (do_accept && need_pop) begin
         busy_in = busy_ff - CNT_W'(1);
      end else if (do_insert && (busy_ff < CNT_W'(MAX_WORKERS))) begin
         busy_in = busy_ff + CNT_W'(1);
      end
   end

   // Chain operation
   always_comb begin
      chain_op.shift  = do_accept && need_pop;
      chain_op.insert = do_insert && (busy_ff < CNT_W'(MAX_WORKERS));
      chain_op.key    = finish_ff;
   end

   efws_chain #(
      .DEPTH (MAX_WORKERS)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .op         (chain_op),
      .head_val   (head_val),
      .head_valid (head_valid)
   );

   assign makespan_new = (finish_ff > max_finish_ff) ? finish_ff : max_finish_ff;

   // Control and time state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         clock_now_ff  <= '0;
         max_finish_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         clock_now_ff <= clock_now_in;
         if (do_insert) begin
            max_finish_ff <= makespan_new;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_beat) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      finish_ff   <= finish_in;
      released_ff <= released_in;
      if (do_insert) begin
         rsp_finish_ff   <= finish_ff;
         rsp_released_ff <= released_ff;
         rsp_makespan_ff <= makespan_new;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_makespan_ff, rsp_released_ff, rsp_finish_ff};

   // Checks
   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff <= CNT_W'(MAX_WORKERS))
      else $error("busy count above chain depth");

   a_head_matches_count: assert property (@(posedge clock) disable iff (reset)
      (busy_ff != '0) == head_valid)
      else $error("chain head validity disagrees with busy count");

   a_accept_to_insert: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == efws_pkg::S_INSERT))
      else $error("accepted job did not reach insert");

   a_finish_after_clock: assert property (@(posedge clock) disable iff (reset)
      (state_ff == efws_pkg::S_INSERT) |-> (finish_ff >= clock_now_ff))
      else $error("finish time earlier than clock");

   a_no_shift_and_insert: assert property (@(posedge clock) disable iff (reset)
      !(chain_op.shift && chain_op.insert))
      else $error("chain asked to remove and insert together");

endmodule
